// File: sv/sbrd_pkg.sv
`timescale 1ns / 1ps

package sbrd_pkg;

	localparam logic [5:0] SymMask = 6'h3F;
	localparam logic [5:0] RunFlag = 6'h20;
	localparam logic [5:0] LenMask = 6'h1F;
	localparam int unsigned SymBits = 6;
	localparam logic [2:0] MaxHeld = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       packed_region;
		logic       last_byte;
	} sbrd_in_t;

	typedef struct packed {
		logic [5:0] symbol_value;
		logic [5:0] repeat_count;
		logic       last_of_input;
		logic       stream_end;
		logic       truncated_error;
	} sbrd_out_t;

	typedef struct packed {
		logic       emit;
		logic [5:0] value;
		logic [5:0] count;
		logic [5:0] lit_next;
	} sbrd_sym_t;

	// A pending literal count wins over the run flag.
	function automatic sbrd_sym_t sbrd_take(input logic [5:0] sym, input logic [5:0] lit);
		sbrd_sym_t r;
		r.emit     = 1'b1;
		r.value    = '0;
		r.count    = 6'd1;
		r.lit_next = lit;
		if (lit != 6'd0) begin
			r.value    = sym & SymMask;
			r.lit_next = lit - 6'd1;
		end else if ((sym & RunFlag) != 6'd0) begin
			r.emit     = 1'b0;
			r.lit_next = (sym & LenMask) + 6'd1;
		end else begin
			r.count = (sym & LenMask) + 6'd1;
		end
		return r;
	endfunction

endpackage

// File: sv/six_bit_run_decompressor_unit.sv
`timescale 1ns / 1ps

// Six-bit run decompressor.
// Input channel (in_valid/in_ready/in_data) takes one compressed word per
// handshake, tagged as packed or direct and marked on the final word of a stream.
// Output channel (out_valid/out_ready/out_data) returns value and repeat-count
// words; last_of_input closes the words caused by one input word, stream_end
// closes the stream and truncated_error flags missing literals at its end.
// A stream end that yields no symbol produces one marker word with count zero.
// The first result passes through the input register and then the output
// register before the receiver can take it. An input word yielding at most one
// result leaves the input register as its result, if any, is loaded, so such
// words flow at one per cycle while the receiver does not stall; a packed word
// that yields two results holds the input register until both are loaded,
// since the single output register takes one result per cycle.
// When the receiver stalls, the output register holds its word and the input
// register fills, after which in_ready drops. Reset empties both registers and
// clears the bit accumulator and the pending literal count; no clearing pass.
module six_bit_run_decompressor_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sbrd_pkg::sbrd_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output sbrd_pkg::sbrd_out_t out_data
);
	import sbrd_pkg::*;

	logic       s1_valid_s1;
	sbrd_in_t   item_s1;
	logic       phase_q;
	logic [3:0] acc_q;
	logic [2:0] held_q;
	logic [5:0] lit_q;
	logic       out_valid_q;
	sbrd_out_t  out_q;

	logic [2:0]  held_c;
	logic [3:0]  acc_mask;
	logic [11:0] comb;
	logic        two_sym;
	logic [5:0]  sym0;
	logic [5:0]  sym1;
	sbrd_sym_t   t0;
	sbrd_sym_t   t1;
	logic        e1;
	logic [1:0]  n_res;
	logic [1:0]  n_eff;
	logic [5:0]  lit_fin;
	logic [3:0]  acc_next;
	logic [2:0]  held_next;
	sbrd_out_t   res0;
	sbrd_out_t   res1;
	sbrd_out_t   sel;
	logic        load_ok;
	logic        emit_now;
	logic        finish;

	always_comb begin
		held_c   = (held_q > MaxHeld) ? MaxHeld : held_q;
		acc_mask = 4'((5'd1 << held_c) - 5'd1);
		comb     = (12'(item_s1.data_byte) << held_c) | 12'(acc_q & acc_mask);
		two_sym  = item_s1.packed_region && (held_c == MaxHeld);
		sym0     = item_s1.packed_region ? comb[5:0] : item_s1.data_byte[5:0];
		sym1     = comb[11:6];
		t0       = sbrd_take(sym0, lit_q);
		t1       = sbrd_take(sym1, t0.lit_next);
		e1       = two_sym && t1.emit;
		n_res    = {1'b0, t0.emit} + {1'b0, e1};
		lit_fin  = two_sym ? t1.lit_next : t0.lit_next;
		n_eff    = (item_s1.last_byte && (n_res == 2'd0)) ? 2'd1 : n_res;

		if (!item_s1.packed_region || two_sym) begin
			acc_next  = '0;
			held_next = '0;
		end else begin
			acc_next  = comb[9:6];
			held_next = held_c + 3'd2;
		end

		res0 = '0;
		if (t0.emit) begin
			res0.symbol_value = t0.value;
			res0.repeat_count = t0.count;
		end else if (e1) begin
			res0.symbol_value = t1.value;
			res0.repeat_count = t1.count;
		end
		res1 = '0;
		res1.symbol_value = t1.value;
		res1.repeat_count = t1.count;

		sel = phase_q ? res1 : res0;
		if (phase_q || (n_eff == 2'd1)) begin
			sel.last_of_input   = 1'b1;
			sel.stream_end      = item_s1.last_byte;
			sel.truncated_error = item_s1.last_byte && (lit_fin != 6'd0);
		end

		load_ok  = !out_valid_q || out_ready;
		emit_now = s1_valid_s1 && (n_eff != 2'd0) && load_ok;
		finish   = s1_valid_s1 && ((n_eff == 2'd0) ||
			(load_ok && (phase_q || (n_eff == 2'd1))));
	end

	assign in_ready  = !s1_valid_s1 || finish;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			phase_q     <= 1'b0;
			acc_q       <= '0;
			held_q      <= '0;
			lit_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				s1_valid_s1 <= in_valid;
			end
			if (finish) begin
				phase_q <= 1'b0;
				if (item_s1.last_byte) begin
					acc_q  <= '0;
					held_q <= '0;
					lit_q  <= '0;
				end else begin
					acc_q  <= acc_next;
					held_q <= held_next;
					lit_q  <= lit_fin;
				end
			end else if (emit_now) begin
				phase_q <= 1'b1;
			end
			if (load_ok) begin
				out_valid_q <= emit_now;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			item_s1 <= in_data;
		end
		if (emit_now) begin
			out_q <= sel;
		end
	end

`ifndef SYNTHESIS
	a_phase_two: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (s1_valid_s1 && (n_res == 2'd2)))
		else $error("second result pending without a two-result word");

	a_held_even: assert property (@(posedge clk) disable iff (!arst_n)
		(held_q == 3'd0) || (held_q == 3'd2) || (held_q == 3'd4))
		else $error("bit count left an unreachable value");

	a_end_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.stream_end) |-> out_q.last_of_input)
		else $error("stream end on a word that does not close its input");

	a_err_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.truncated_error) |-> out_q.stream_end)
		else $error("truncation flagged before the stream end");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && item_s1.last_byte) |=> ((lit_q == 6'd0) && (held_q == 3'd0)))
		else $error("state not cleared after the last word");
`endif

endmodule
